/* hw/rtl/itoa_pkg.sv */
// Shared types, constants and a helper function for the integer-to-text block.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_WIDTH     = 6;
    localparam int CHAR_WIDTH      = 7;
    localparam int DIGIT_WIDTH     = 6;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = 6'd10;

    localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR  = 7'd45;
    localparam logic [CHAR_WIDTH-1:0] ZERO_CHAR   = 7'd48;
    localparam logic [CHAR_WIDTH-1:0] LETTER_BASE = 7'd55;  // 'A' - 10

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_SIGN,
        S_READ,
        S_EMIT
    } itoa_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic pop;
        logic sel_sign;
    } itoa_cmd_t;

    typedef struct packed {
        logic step_done;
        logic quot_zero;
        logic neg;
        logic idx_zero;
    } itoa_status_t;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] ext;
        ext = {1'b0, d};
        if (d < 6'd10)
        begin
            digit_char = ZERO_CHAR + ext;
        end
        else
        begin
            digit_char = LETTER_BASE + ext;
        end
    endfunction

endpackage

/* hw/rtl/itoa_in_if.sv */
// Input channel: one integer and its radix per item.
interface itoa_in_if #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [VALUE_WIDTH-1:0]        number;
    logic [itoa_pkg::RADIX_WIDTH-1:0]     radix;

    modport source (output valid, output number, output radix, input ready);
    modport sink   (input valid, input number, input radix, output ready);
endinterface

/* hw/rtl/itoa_out_if.sv */
// Output channel: one ASCII character per item, with a last-character flag.
interface itoa_out_if;
    logic                              valid;
    logic                              ready;
    logic [itoa_pkg::CHAR_WIDTH-1:0]   character;
    logic                              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

/* hw/rtl/itoa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* hw/rtl/itoa_datapath.sv */
// Datapath: bit-serial divider by the radix, digit stack and character output.
module itoa_datapath #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  itoa_pkg::itoa_cmd_t                   cmd,
    output itoa_pkg::itoa_status_t                status,
    input  logic signed [VALUE_WIDTH-1:0]         number,
    input  logic [itoa_pkg::RADIX_WIDTH-1:0]      radix,
    output logic [itoa_pkg::CHAR_WIDTH-1:0]       character,
    output logic                                  last
);
    import itoa_pkg::*;

    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [DIGIT_WIDTH-1:0] rem_reg, rem_next;
    logic [RADIX_WIDTH-1:0] rad_reg, rad_next;
    logic [AW-1:0]          step_reg, step_next;
    logic [CW-1:0]          dcnt_reg, dcnt_next;
    logic                   neg_reg, neg_next;

    logic [RADIX_WIDTH-1:0] rad_sat;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [DIGIT_WIDTH:0]   trial;
    logic [DIGIT_WIDTH:0]   diff;
    logic                   ge;
    logic [DIGIT_WIDTH-1:0] rem_step;
    logic [CW-1:0]          dcnt_m1;
    logic [DIGIT_WIDTH-1:0] rd_digit;

    always_comb
    begin
        if (radix < RADIX_MIN)
        begin
            rad_sat = RADIX_MIN;
        end
        else if (radix > RADIX_MAX)
        begin
            rad_sat = RADIX_MAX;
        end
        else
        begin
            rad_sat = radix;
        end
        neg_in = (rad_sat == RADIX_DECIMAL) && number[VALUE_WIDTH-1];
        // The most negative value negates to itself, read as unsigned magnitude.
        mag_in = neg_in ? (~number + VALUE_WIDTH'(1)) : number;
    end

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, val_reg[VALUE_WIDTH-1]};
        diff     = trial - {1'b0, rad_reg};
        ge       = trial >= {1'b0, rad_reg};
        rem_step = ge ? diff[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
    end

    assign dcnt_m1 = dcnt_reg - CW'(1);

    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        step_next = step_reg;
        dcnt_next = dcnt_reg;
        neg_next  = neg_reg;
        if (cmd.load)
        begin
            val_next  = mag_in;
            rem_next  = '0;
            rad_next  = rad_sat;
            step_next = '0;
            dcnt_next = '0;
            neg_next  = neg_in;
        end
        else if (cmd.step)
        begin
            val_next  = {val_reg[VALUE_WIDTH-2:0], ge};
            rem_next  = rem_step;
            step_next = step_reg + AW'(1);
        end
        else if (cmd.store)
        begin
            rem_next  = '0;
            step_next = '0;
            dcnt_next = dcnt_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            dcnt_next = dcnt_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            rad_reg  <= RADIX_MIN;
            step_reg <= '0;
            dcnt_reg <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            rad_reg  <= rad_next;
            step_reg <= step_next;
            dcnt_reg <= dcnt_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // Digits are pushed least significant first and popped in reverse.
    itoa_ram #(
        .WIDTH (DIGIT_WIDTH),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (dcnt_reg[AW-1:0]),
        .wr_data (rem_reg),
        .rd_en   (cmd.pop),
        .rd_addr (dcnt_m1[AW-1:0]),
        .rd_data (rd_digit)
    );

    always_comb
    begin
        status.step_done = (step_reg == AW'(VALUE_WIDTH - 1));
        status.quot_zero = (val_reg == '0);
        status.neg       = neg_reg;
        status.idx_zero  = (dcnt_reg == '0);
    end

    assign character = cmd.sel_sign ? MINUS_CHAR : digit_char(rd_digit);
    assign last      = !cmd.sel_sign && (dcnt_reg == '0);

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < rad_reg)
        else $error("remainder not below radix");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> dcnt_reg < CW'(VALUE_WIDTH))
        else $error("digit stack overflow");
`endif
endmodule

/* hw/rtl/itoa_ctrl.sv */
// Controller: sequences load, division passes, digit stores and character output.
module itoa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output itoa_pkg::itoa_cmd_t    cmd,
    input  itoa_pkg::itoa_status_t status
);
    import itoa_pkg::*;

    itoa_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.step_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                if (!status.quot_zero)
                begin
                    state_next = S_DIV;
                end
                else if (status.neg)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = status.idx_zero ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
            end
            S_SIGN:
            begin
                out_valid    = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            S_READ:
            begin
                cmd.pop = 1'b1;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output active together");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_DIV)
        else $error("accepted item did not start division");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_ready && status.idx_zero) |=> state_reg == S_IDLE)
        else $error("final character did not end the item");
`endif
endmodule

/* hw/rtl/integer_to_ascii_radix_top.sv */
// Top level of the integer-to-ASCII converter in radix 2 to 36.
//
// Usage:
//   items: one signed integer (number) and a radix per item. A radix below 2
//   is taken as 2, above 36 as 36. In radix 10 a negative number prints as
//   '-' and its magnitude; in other radixes the bit pattern is unsigned.
//   chars: one ASCII character per item, most significant digit first, with
//   last high on the final character of the text.
//   Each digit takes one pass of a bit-serial restoring divider: one step
//   per dividend bit, then a store to the digit stack. Each digit character
//   is then read from the digit stack and output; a leading '-' is output
//   directly. One item is in work at a time: items.ready is high only when
//   no item is in work.
//   A receiver stall holds the current character and freezes the sequence.
//   Reset returns the block to idle and drops any text not yet delivered.
module integer_to_ascii_radix_top #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    items,
    itoa_out_if.source chars
);
    import itoa_pkg::*;

    itoa_cmd_t    cmd;
    itoa_status_t status;

    itoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_valid (chars.valid),
        .out_ready (chars.ready),
        .cmd       (cmd),
        .status    (status)
    );

    itoa_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .number    (items.number),
        .radix     (items.radix),
        .character (chars.character),
        .last      (chars.last)
    );
endmodule
